[sv/btp3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btp3_pkg
// shared types and constants for the 3x3 binary thinning pass
// ----------------------------------------------------------------------------
package btp3_pkg;

    // line store depth, also the largest usable row length
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4095;
    localparam int MIN_DIM    = 3;

    // configuration field width
    localparam int DIM_W     = 12;
    localparam int CFG_IDX_W = 2;

    // counter and compare widths
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 3);
    localparam int EMIT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int WCMP_W   = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
    localparam int PROD_W   = WCMP_W + DIM_W;

    // line store word: upper row bit and middle row bit
    localparam int LINE_W   = 2;
    localparam int LINE_UP  = 1;
    localparam int LINE_MID = 0;

    localparam logic [7:0] PIXEL_FG = 8'd255;
    localparam logic [7:0] PIXEL_BG = 8'd0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    typedef struct packed {
        logic pixel_on;
        logic flush;
    } t_in;

    typedef struct packed {
        logic [7:0] out_pixel;
        logic       frame_last;
    } t_out;

    // per item control handed from the counter stage to the window stage
    typedef struct packed {
        logic             pix;
        logic             col_zero;
        logic             emit;
        logic             last;
        logic             interior;
        logic [COL_W-1:0] addr;
    } t_tag;

endpackage

[sv/binary_thinning_pass_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_thinning_pass_3x3
// one 3x3 thinning pass over a raster-order binary image stream
// ----------------------------------------------------------------------------
// Takes one pixel request per clock unless stalled and returns each pixel one
// row and one column later as 255 or 0; after the frame's W*H pixels, send
// W+1 more requests (any flags) to drain it, the last result carries
// frame_last. Flush requests that arrive before the frame is complete are
// accepted and dropped. The accepting cycle steps the raster counters and
// starts the line store ram read; the window stage then builds the window,
// makes the decision, writes the ram back and loads the output register.
// Sustained rate is one request per cycle while results are not stalled, set
// by the single ram read and write per pixel; the output register lets a new
// request in while a result waits. Width and height are written through the
// config port by the user, only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module binary_thinning_pass_3x3 (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel requests
    input  logic                            i_valid,
    input  btp3_pkg::t_in                   i_req,
    output logic                            o_stall,
    // results
    output logic                            o_valid,
    output btp3_pkg::t_out                  o_rsp,
    input  logic                            i_stall,
    // configuration writes
    input  logic                            i_cfg_valid,
    input  logic [btp3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btp3_pkg::DIM_W-1:0]      i_cfg_data,
    output logic                            o_cfg_ready
);

    logic                          take;
    logic                          issue;
    logic                          busy;
    btp3_pkg::t_tag                tag;
    logic                          wr_en;
    logic [btp3_pkg::COL_W-1:0]    wr_addr;
    logic [btp3_pkg::LINE_W-1:0]   wr_data;
    logic [btp3_pkg::LINE_W-1:0]   rd_data;

    // config writes always land at once
    assign o_cfg_ready = 1'b1;

    // the window stage holds back input only while its result cannot leave
    assign o_stall = busy;
    assign take    = i_valid && !busy;

    // raster counters, border and frame end flags
    btp3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_req       (i_req),
        .o_issue     (issue),
        .o_tag       (tag)
    );

    // both line stores share one word per column: upper and middle row bits
    btp3_ram #(
        .WIDTH (btp3_pkg::LINE_W),
        .DEPTH (btp3_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (tag.addr),
        .o_rd_data (rd_data)
    );

    // window update, decision and output register
    btp3_win u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_tag       (tag),
        .i_rd_data   (rd_data),
        .i_out_stall (i_stall),
        .o_busy      (busy),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // a frame end sends the counters back to the first column, with no result
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && tag.last) |=> (tag.addr == '0 && !tag.emit))
        else $error("counters not cleared after frame end");

    // an interior pixel always produces a result from the window centre
    a_interior_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && tag.interior) |-> (tag.emit && !tag.col_zero))
        else $error("interior pixel without a result");

    // a line store write belongs to a request issued earlier
    a_write_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ($past(issue) || $past(busy)))
        else $error("line store write without a pending request");

    // results are only ever full scale or zero
    a_pixel_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.out_pixel == btp3_pkg::PIXEL_FG
                     || o_rsp.out_pixel == btp3_pkg::PIXEL_BG))
        else $error("result pixel not 0 or 255");
`endif

endmodule

[sv/btp3_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btp3_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module btp3_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/btp3_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btp3_ctrl
// configuration registers and raster counters, builds the per item tag
// ----------------------------------------------------------------------------
module btp3_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr,
    input  logic [btp3_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [btp3_pkg::DIM_W-1:0]      i_cfg_data,
    input  logic                            i_take,
    input  btp3_pkg::t_in                   i_req,
    output logic                            o_issue,
    output btp3_pkg::t_tag                  o_tag
);

    localparam int COL_W  = btp3_pkg::COL_W;
    localparam int ROW_W  = btp3_pkg::ROW_W;
    localparam int EMIT_W = btp3_pkg::EMIT_W;
    localparam int WCMP_W = btp3_pkg::WCMP_W;
    localparam int PROD_W = btp3_pkg::PROD_W;
    localparam int DIM_W  = btp3_pkg::DIM_W;

    logic [DIM_W-1:0]  r_width, r_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [EMIT_W-1:0] r_emitted, n_emitted;

    logic [WCMP_W-1:0] w_dim, v_ext;
    logic [DIM_W-1:0]  h_dim;
    logic [ROW_W-1:0]  h_ext;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [EMIT_W:0]   emit_inc;
    logic [PROD_W-1:0] area;
    logic              drain, ignored, wrap, emit, last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= btp3_pkg::RST_IMAGE_WIDTH;
            r_height <= btp3_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                btp3_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                btp3_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        // clamp the row length between MIN_DIM and the line store depth, the height between MIN_DIM and MAX_HEIGHT
        v_ext = WCMP_W'(r_width);
        if (v_ext < WCMP_W'(btp3_pkg::MIN_DIM)) begin
            w_dim = WCMP_W'(btp3_pkg::MIN_DIM);
        end else if (v_ext > WCMP_W'(btp3_pkg::MAX_WIDTH)) begin
            w_dim = WCMP_W'(btp3_pkg::MAX_WIDTH);
        end else begin
            w_dim = v_ext;
        end
        if (r_height < DIM_W'(btp3_pkg::MIN_DIM)) begin
            h_dim = DIM_W'(btp3_pkg::MIN_DIM);
        end else if (r_height > DIM_W'(btp3_pkg::MAX_HEIGHT)) begin
            h_dim = DIM_W'(btp3_pkg::MAX_HEIGHT);
        end else begin
            h_dim = r_height;
        end
        h_ext = ROW_W'(h_dim);

        col_inc  = {1'b0, r_col} + (COL_W+1)'(1);
        row_inc  = {1'b0, r_row} + (ROW_W+1)'(1);
        emit_inc = {1'b0, r_emitted} + (EMIT_W+1)'(1);
        area     = PROD_W'(w_dim) * PROD_W'(h_dim);

        drain   = r_row >= h_ext;
        ignored = !drain && i_req.flush;
        wrap    = WCMP_W'(col_inc) >= w_dim;
        emit    = (r_row >= ROW_W'(2)) || (r_row == ROW_W'(1) && r_col != '0);
        last    = emit && (PROD_W'(emit_inc) >= area);

        o_issue         = i_take && !ignored;
        o_tag.pix       = !drain && i_req.pixel_on;
        o_tag.col_zero  = r_col == '0;
        o_tag.emit      = emit;
        o_tag.last      = last;
        o_tag.interior  = (r_row >= ROW_W'(2)) && (row_inc <= {1'b0, h_ext})
                          && (r_col >= COL_W'(2)) && (WCMP_W'(col_inc) <= w_dim);
        o_tag.addr      = r_col;

        n_col     = r_col;
        n_row     = r_row;
        n_emitted = r_emitted;
        if (o_issue) begin
            if (last) begin
                n_col     = '0;
                n_row     = '0;
                n_emitted = '0;
            end else begin
                if (wrap) begin
                    n_col = '0;
                    n_row = row_inc[ROW_W-1:0];
                end else begin
                    n_col = col_inc[COL_W-1:0];
                end
                if (emit) begin
                    n_emitted = emit_inc[EMIT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_emitted <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_emitted <= n_emitted;
        end
    end

endmodule

[sv/btp3_win.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btp3_win
// line store write back, 3x3 window, thinning decision and output register
// ----------------------------------------------------------------------------
module btp3_win (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_issue,
    input  btp3_pkg::t_tag                i_tag,
    input  logic [btp3_pkg::LINE_W-1:0]   i_rd_data,
    input  logic                          i_out_stall,
    output logic                          o_busy,
    output logic                          o_wr_en,
    output logic [btp3_pkg::COL_W-1:0]    o_wr_addr,
    output logic [btp3_pkg::LINE_W-1:0]   o_wr_data,
    output logic                          o_valid,
    output btp3_pkg::t_out                o_rsp
);

    // 1 when the foreground centre of window w is to be deleted
    function automatic logic delete_centre(logic [8:0] w);
        logic [7:0] f;
        logic [7:0] t;
        logic [3:0] a;
        logic [3:0] b;
        logic       sel;
        logic       res;
        f = {w[8], w[7], w[6], w[3], w[0], w[1], w[2], w[5]};
        t = f ^ {f[0], f[7:1]};
        a = '0;
        b = '0;
        for (int n = 0; n < 8; n++) begin
            a = a + 4'(t[n]);
            b = b + 4'(f[n]);
        end
        res = 1'b0;
        if ((a == 4'd0 || a == 4'd2 || a == 4'd4) && b != 4'd1) begin
            sel = !(f[0] && f[2] && f[4]) && !(f[0] && f[2] && f[6]);
            if (sel) begin
                res = (a != 4'd4)
                    || (f[0] && f[6] && (f[1] || f[5]) && !(f[2] || f[3] || f[4] || f[7]))
                    || (f[0] && f[2] && (f[3] || f[7]) && !(f[1] || f[4] || f[5] || f[6]));
            end else if (!(f[2] && f[4] && f[6]) && !(f[4] && f[6] && f[0])) begin
                res = (a != 4'd4)
                    || (f[4] && f[2] && (f[5] || f[1]) && !(f[0] || f[3] || f[6] || f[7]))
                    || (f[6] && f[4] && (f[7] || f[3]) && !(f[0] || f[5] || f[2] || f[1]));
            end
        end
        return res;
    endfunction

    logic                         r_s1_vld;
    btp3_pkg::t_tag               r_s1;
    logic                         r_fwd, n_fwd;
    logic [btp3_pkg::LINE_W-1:0]  r_fwd_data;
    logic [8:0]                   r_win, n_win;
    logic                         r_out_vld;
    btp3_pkg::t_out               r_out, n_out;

    logic [btp3_pkg::LINE_W-1:0]  line;
    logic                         top, mid, keep, out_free, s1_go;

    always_comb begin
        // forwarded word replaces the ram word when the entry was just written
        line     = r_fwd ? r_fwd_data : i_rd_data;
        top      = line[btp3_pkg::LINE_UP];
        mid      = line[btp3_pkg::LINE_MID];
        n_win    = {r_s1.pix, r_win[8:7], mid, r_win[5:4], top, r_win[2:1]};

        out_free = !r_out_vld || !i_out_stall;
        s1_go    = r_s1_vld && (!r_s1.emit || out_free);
        o_busy   = r_s1_vld && !s1_go;

        if (r_s1.col_zero) begin
            keep = r_win[5];
        end else begin
            keep = n_win[4] && !(r_s1.interior && delete_centre(n_win));
        end
        n_out.out_pixel  = keep ? btp3_pkg::PIXEL_FG : btp3_pkg::PIXEL_BG;
        n_out.frame_last = r_s1.last;

        o_wr_en   = s1_go;
        o_wr_addr = r_s1.addr;
        o_wr_data = {mid, r_s1.pix};

        n_fwd = i_issue && s1_go && (i_tag.addr == r_s1.addr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd     <= 1'b0;
            r_win     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_issue) begin
                r_s1_vld <= 1'b1;
                r_fwd    <= n_fwd;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_go) begin
                r_win <= r_s1.last ? 9'd0 : n_win;
            end
            if (s1_go && r_s1.emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_s1       <= i_tag;
            r_fwd_data <= {mid, r_s1.pix};
        end
        if (s1_go && r_s1.emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

endmodule

[verif/binary_thinning_pass_3x3_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_thinning_pass_3x3_test
// self-checking bench for the 3x3 binary thinning pass
// ----------------------------------------------------------------------------
// Streams binary frames into the block, one pixel request per handshake, and
// follows each frame with the drain requests that push the delayed row out.
// A behavioral model of the thinning decision, the line stores and the raster
// counters runs beside the block and queues the expected pixel for each
// accepted request that yields one; results are checked in order against it.
// The run covers the power-up frame size, a small hand-built frame, the
// widest and the tallest size settings cut short by a size change, and many
// small random frames of varying density, with occasional size changes while
// the pipeline is empty.
// ----------------------------------------------------------------------------
module binary_thinning_pass_3x3_test;

    localparam int          DIM_W         = btp3_pkg::DIM_W;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned RANDOM_ITEMS  = 450;
    // two stage pipeline plus output register, with margin
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned SMOKE_LEN     = 15;
    localparam int unsigned IDLE_MAX      = 14;

    // one row of the hand-built frame: request flags and, where known, the result
    typedef struct packed {
        logic       pix;
        logic       flush;
        logic       typed;
        logic [7:0] want_pixel;
        logic       want_last;
    } t_smoke_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    btp3_pkg::t_in                  i_req;
    logic                           o_stall;
    logic                           o_valid;
    btp3_pkg::t_out                 o_rsp;
    logic                           i_stall;
    logic                           i_cfg_valid;
    logic [btp3_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]               i_cfg_data;
    logic                           o_cfg_ready;

    // model copy of the registers and the block state
    logic [DIM_W-1:0] reg_width;
    logic [DIM_W-1:0] reg_height;
    bit               line_up  [btp3_pkg::MAX_WIDTH];
    bit               line_mid [btp3_pkg::MAX_WIDTH];
    logic [8:0]       win;
    int unsigned      col_count;
    int unsigned      row_count;
    int unsigned      emitted_count;
    bit               frame_done;

    // pixels still owed by the block, oldest first
    btp3_pkg::t_out   awaited_pixels [$];
    btp3_pkg::t_out   oldest;

    t_smoke_row       smoke_rows [SMOKE_LEN];
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;

    binary_thinning_pass_3x3 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_req       (i_req),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // runaway guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_pixels.size());
            $display("** binary_thinning_pass_3x3: FAILED **");
            $finish;
        end
    end

    // register value as the block uses it
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned hi);
        if (v < btp3_pkg::MIN_DIM) return btp3_pkg::MIN_DIM;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // deletion test for a foreground centre; window bit y*3+x, y=0 top row
    function automatic bit thin_delete(input logic [8:0] w);
        bit [8:0]    f;
        int unsigned a;
        int unsigned b;
        int          n;
        // neighbours counter-clockwise from the right, f8 wraps to f0
        f[0] = w[5]; f[1] = w[2]; f[2] = w[1]; f[3] = w[0];
        f[4] = w[3]; f[5] = w[6]; f[6] = w[7]; f[7] = w[8];
        f[8] = w[5];
        a = 0;
        b = 0;
        for (n = 0; n < 8; n++) begin
            a += 32'(f[n + 1] ^ f[n]);
            b += 32'(f[n]);
        end
        if (!((a == 0 || a == 2 || a == 4) && b != 1)) return 1'b0;
        // first side group: right / top / left and right / top / bottom
        if (!(f[0] && f[2] && f[4]) && !(f[0] && f[2] && f[6])) begin
            if (a != 4) return 1'b1;
            if (f[0] && f[6] && (f[1] || f[5]) && !(f[2] || f[3] || f[4] || f[7]))
                return 1'b1;
            if (f[0] && f[2] && (f[3] || f[7]) && !(f[1] || f[4] || f[5] || f[6]))
                return 1'b1;
            return 1'b0;
        end
        // second side group: top / left / bottom and left / bottom / right
        if (!(f[2] && f[4] && f[6]) && !(f[4] && f[6] && f[0])) begin
            if (a != 4) return 1'b1;
            if (f[4] && f[2] && (f[5] || f[1]) && !(f[0] || f[3] || f[6] || f[7]))
                return 1'b1;
            if (f[6] && f[4] && (f[7] || f[3]) && !(f[0] || f[5] || f[2] || f[1]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // advance the model by one accepted request
    task automatic thin_step(input btp3_pkg::t_in req, output bit dropped,
                             output bit produced, output btp3_pkg::t_out rsp);
        int unsigned wd;
        int unsigned ht;
        int unsigned c;
        int unsigned r;
        int unsigned idx;
        int unsigned orow;
        int unsigned ocol;
        bit          v;
        bit          pre_right;
        bit          top;
        bit          mid;
        bit          emit;
        bit          last;
        bit          val;
        logic [8:0]  nw;
        wd       = clamp_dim(reg_width, btp3_pkg::MAX_WIDTH);
        ht       = clamp_dim(reg_height, btp3_pkg::MAX_HEIGHT);
        c        = col_count;
        r        = row_count;
        produced = 1'b0;
        rsp      = '0;
        // flush while the frame is still arriving is dropped outright
        dropped  = (r < ht) && req.flush;
        if (dropped) return;
        // once all rows are in, every request drains with a background pixel
        v         = (r >= ht) ? 1'b0 : req.pixel_on;
        pre_right = win[5];
        idx       = (c < btp3_pkg::MAX_WIDTH) ? c : 0;
        top       = line_up[idx];
        mid       = line_mid[idx];
        line_up[idx]  = mid;
        line_mid[idx] = v;
        // shift the window one column left, new column enters on the right
        nw  = {v, win[8:7], mid, win[5:4], top, win[2:1]};
        win = nw;
        emit = (r >= 2) || (r == 1 && c >= 1);
        val  = 1'b0;
        if (emit) begin
            if (c == 0) begin
                // last pixel of the previous row, still in the old window
                val = pre_right;
            end else begin
                orow = r - 1;
                ocol = c - 1;
                val  = nw[4];
                if (nw[4] && orow >= 1 && orow + 2 <= ht && ocol >= 1 && ocol + 2 <= wd
                    && thin_delete(nw))
                    val = 1'b0;
            end
        end
        if (c + 1 >= wd) begin
            col_count = 0;
            row_count = r + 1;
        end else begin
            col_count = c + 1;
        end
        if (!emit) return;
        last = (emitted_count + 1 >= wd * ht);
        if (last) begin
            col_count     = 0;
            row_count     = 0;
            emitted_count = 0;
            win           = '0;
            frame_done    = 1'b1;
        end else begin
            emitted_count++;
        end
        produced       = 1'b1;
        rsp.out_pixel  = val ? btp3_pkg::PIXEL_FG : btp3_pkg::PIXEL_BG;
        rsp.frame_last = last;
    endtask

    // one pixel request after a random gap; called and returns at a falling edge
    task automatic send_req(input btp3_pkg::t_in req, input bit typed,
                            input btp3_pkg::t_out want, output bit dropped);
        int unsigned    gap;
        bit             produced;
        btp3_pkg::t_out rsp;
        gap = $urandom_range(0, IDLE_MAX);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_stall);
        thin_step(req, dropped, produced, rsp);
        // hand-typed rows stand in for the model's answer
        if (typed) awaited_pixels.push_back(want);
        else if (produced) awaited_pixels.push_back(rsp);
        @(negedge i_clk);
    endtask

    // stop sending and let the pipeline empty before touching the registers
    task automatic quiesce();
        i_valid <= 1'b0;
        while (awaited_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // width then height, valid held high across both writes
    task automatic write_dims(input logic [DIM_W-1:0] width_val,
                              input logic [DIM_W-1:0] height_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= btp3_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data  <= width_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_width = width_val;
        @(negedge i_clk);
        i_cfg_index <= btp3_pkg::CFG_IMAGE_HEIGHT;
        i_cfg_data  <= height_val;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_height = height_val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random frame through to its last pixel; optional size change part way,
    // width never grows there so every line store column read was written
    task automatic run_frame(input int unsigned density, input int unsigned flush_pct,
                             input int change_at, input int unsigned new_w,
                             input int unsigned new_h, output int unsigned sent);
        int            trigger;
        int unsigned   w_now;
        bit            dropped;
        btp3_pkg::t_in req;
        trigger    = change_at;
        sent       = 0;
        frame_done = 1'b0;
        while (!frame_done) begin
            if (trigger >= 0 && sent == trigger) begin
                trigger = -1;
                quiesce();
                w_now = clamp_dim(reg_width, btp3_pkg::MAX_WIDTH);
                write_dims(DIM_W'((new_w != 0) ? new_w
                                  : $urandom_range(btp3_pkg::MIN_DIM, w_now)),
                           DIM_W'((new_h != 0) ? new_h
                                  : $urandom_range(btp3_pkg::MIN_DIM, 12)));
            end
            req.pixel_on = ($urandom_range(0, 99) < density);
            req.flush    = ($urandom_range(0, 99) < flush_pct);
            send_req(req, 1'b0, '0, dropped);
            if (!dropped) sent++;
        end
    endtask

    // result side: random stall before each result, then accept it
    initial begin : result_sink
        int unsigned hold;
        i_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            hold = $urandom_range(0, IDLE_MAX);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            @(negedge i_clk);
        end
    end

    // compare every accepted result with the oldest owed pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result at cycle %0d: pixel %0d last %0d",
                             cycle_count, o_rsp.out_pixel, o_rsp.frame_last);
            end else begin
                oldest = awaited_pixels.pop_front();
                if (o_rsp.out_pixel !== oldest.out_pixel
                    || o_rsp.frame_last !== oldest.frame_last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch at cycle %0d: expected %0d last %0d, got %0d last %0d",
                                 cycle_count, oldest.out_pixel, oldest.frame_last,
                                 o_rsp.out_pixel, o_rsp.frame_last);
                end
            end
        end
    end

    initial begin : main_seq
        int unsigned    k;
        int unsigned    wr;
        int unsigned    hr;
        int unsigned    density;
        int unsigned    random_items;
        int unsigned    frame_items;
        int             change_at;
        bit             dropped;
        btp3_pkg::t_in  req;
        btp3_pkg::t_out want;

        // model state as after reset
        reg_width  = btp3_pkg::RST_IMAGE_WIDTH;
        reg_height = btp3_pkg::RST_IMAGE_HEIGHT;
        for (k = 0; k < btp3_pkg::MAX_WIDTH; k++) begin
            line_up[k]  = 1'b0;
            line_mid[k] = 1'b0;
        end
        win           = '0;
        col_count     = 0;
        row_count     = 0;
        emitted_count = 0;
        random_items  = 0;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = btp3_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data  = '0;

        // 3x3 frame, rows 101 / 110 / 011, with in-frame flushes and flagged drains
        smoke_rows = '{
            '{1'b1, 1'b0, 1'b0, btp3_pkg::PIXEL_BG, 1'b0},
            '{1'b0, 1'b0, 1'b0, btp3_pkg::PIXEL_BG, 1'b0},
            '{1'b1, 1'b1, 1'b0, btp3_pkg::PIXEL_BG, 1'b0},  // flush mid-frame, dropped
            '{1'b1, 1'b0, 1'b0, btp3_pkg::PIXEL_BG, 1'b0},
            '{1'b1, 1'b0, 1'b0, btp3_pkg::PIXEL_BG, 1'b0},
            '{1'b1, 1'b0, 1'b1, btp3_pkg::PIXEL_FG, 1'b0},  // first pixel out, top left
            '{1'b0, 1'b0, 1'b1, btp3_pkg::PIXEL_BG, 1'b0},
            '{1'b0, 1'b0, 1'b1, btp3_pkg::PIXEL_FG, 1'b0},  // row start, previous tail
            '{1'b0, 1'b1, 1'b0, btp3_pkg::PIXEL_BG, 1'b0},  // flush mid-frame, dropped
            '{1'b1, 1'b0, 1'b1, btp3_pkg::PIXEL_FG, 1'b0},
            '{1'b1, 1'b0, 1'b0, btp3_pkg::PIXEL_BG, 1'b0},  // centre, only interior pixel
            '{1'b1, 1'b0, 1'b1, btp3_pkg::PIXEL_BG, 1'b0},  // drain, pixel flag ignored
            '{1'b0, 1'b1, 1'b1, btp3_pkg::PIXEL_BG, 1'b0},  // drain with flush set
            '{1'b1, 1'b1, 1'b1, btp3_pkg::PIXEL_FG, 1'b0},
            '{1'b0, 1'b0, 1'b1, btp3_pkg::PIXEL_FG, 1'b1}   // bottom right, end of frame
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // power-up size: one full 640 row and a bit, then shrink to 5x3 mid-frame
        run_frame(50, 3, 650, 5, 3, frame_items);

        // hand-built frame, both sizes written below the minimum
        quiesce();
        write_dims(12'd0, 12'd2);
        for (k = 0; k < SMOKE_LEN; k++) begin
            req.pixel_on    = smoke_rows[k].pix;
            req.flush       = smoke_rows[k].flush;
            want.out_pixel  = smoke_rows[k].want_pixel;
            want.frame_last = smoke_rows[k].want_last;
            send_req(req, smoke_rows[k].typed, want, dropped);
        end

        // widest setting, width written past the line store depth, then shrunk
        quiesce();
        write_dims(12'hFFF, 12'd3);
        run_frame(70, 1, 200, 6, 4, frame_items);

        // tallest setting, then cut short by a lower height
        quiesce();
        write_dims(12'd3, 12'hFFF);
        run_frame(70, 1, 60, 3, 5, frame_items);

        // small random frames
        while (random_items < RANDOM_ITEMS) begin
            quiesce();
            wr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            write_dims(DIM_W'(wr), DIM_W'(hr));
            case ($urandom_range(0, 4))
                0:       density = 5;
                1:       density = 30;
                2:       density = 60;
                3:       density = 85;
                default: density = 97;
            endcase
            change_at = ($urandom_range(0, 3) == 0)
                ? $urandom_range(1, clamp_dim(DIM_W'(wr), btp3_pkg::MAX_WIDTH)
                                    * clamp_dim(DIM_W'(hr), btp3_pkg::MAX_HEIGHT))
                : -1;
            run_frame(density, $urandom_range(0, 8), change_at, 0, 0, frame_items);
            random_items += frame_items;
        end

        // everything owed has come back, give the pipeline time to show strays
        quiesce();
        if (mismatch_count == 0) begin
            $display("** binary_thinning_pass_3x3: PASSED **");
        end else begin
            $display("** binary_thinning_pass_3x3: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
sv/btp3_pkg.sv
sv/btp3_ram.sv
sv/btp3_ctrl.sv
sv/btp3_win.sv
sv/binary_thinning_pass_3x3.sv
verif/binary_thinning_pass_3x3_test.sv
